// ===== src/assert_macros.svh =====
// assertion macros shared by the advection-diffusion stepper rtl
// the macros expect signals named clk and rst_n in the enclosing module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ADV_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ADV_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ADV_ASSERT(lbl, prop)
`define ADV_NEVER(lbl, cond)
`endif
`endif

// ===== src/adv1d_pkg.sv =====
// types, codes and constants of the 1d advection-diffusion stepper
// no dependencies; imported by every module of the block
package adv1d_pkg;

    localparam int Q_W   = 32;
    localparam int SUM_W = 51;

    localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_ADVANCE = 2'd1;
    localparam logic [1:0] REQ_READ    = 2'd2;

    localparam logic [2:0] CFG_ACTIVE_CELLS  = 3'd0;
    localparam logic [2:0] CFG_INV_DELTA     = 3'd1;
    localparam logic [2:0] CFG_HALF_VELOCITY = 3'd2;
    localparam logic [2:0] CFG_LW_COEF       = 3'd3;
    localparam logic [2:0] CFG_DT_OVER_DELTA = 3'd4;

    localparam logic [6:0]           RST_ACTIVE_CELLS  = 7'd64;
    localparam logic signed [Q_W-1:0] RST_INV_DELTA     = 32'sd425984;
    localparam logic signed [Q_W-1:0] RST_HALF_VELOCITY = 32'sd65536;
    localparam logic signed [Q_W-1:0] RST_LW_COEF       = 32'sd12779;
    localparam logic signed [Q_W-1:0] RST_DT_OVER_DELTA = 32'sd6291;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SWEEP,
        ST_DRAIN
    } adv1d_state_t;

    typedef struct packed {
        logic signed [Q_W-1:0] inv_delta;
        logic signed [Q_W-1:0] half_velocity;
        logic signed [Q_W-1:0] lw_coef;
        logic signed [Q_W-1:0] dt_over_delta;
    } coef_t;

    // tag of one sweep read beat
    typedef struct packed {
        logic valid;
        logic skip;
        logic first;
        logic last;
    } rd_beat_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } stage_tag_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic ovf;
        logic signed [Q_W-1:0] q;
        logic signed [Q_W-1:0] tc;
    } flux_beat_t;

    typedef struct packed {
        logic valid;
        logic last;
    } upd_tag_t;

    typedef struct packed {
        logic done;
        logic ovf;
    } upd_status_t;

    typedef struct packed {
        logic ovf;
        logic signed [Q_W-1:0] val;
    } sat_t;

    function automatic sat_t sat32(input logic signed [SUM_W-1:0] v);
        sat_t r;
        logic [SUM_W-1:Q_W-1] hi;
        hi = v[SUM_W-1:Q_W-1];
        if ((&hi) || (~|hi))
        begin
            r.ovf = 1'b0;
            r.val = v[Q_W-1:0];
        end
        else
        begin
            r.ovf = 1'b1;
            r.val = v[SUM_W-1] ? Q_MIN : Q_MAX;
        end
        return r;
    endfunction

endpackage

// ===== src/adv1d_cell_mem.sv =====
// grid cell storage: one write port, one read port, registered read data
// uses adv1d_pkg for the cell width
module adv1d_cell_mem #(
    parameter int GRID_CELLS = 64
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [$clog2(GRID_CELLS)-1:0]     waddr,
    input  logic signed [adv1d_pkg::Q_W-1:0]  wdata,
    input  logic                              re,
    input  logic [$clog2(GRID_CELLS)-1:0]     raddr,
    output logic signed [adv1d_pkg::Q_W-1:0]  rdata
);
    import adv1d_pkg::*;

    logic signed [Q_W-1:0] cell_mem [GRID_CELLS];
    logic signed [Q_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            cell_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= cell_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/adv1d_flux.sv =====
// face flux pipeline: takes the swept cell stream and forms one flux per face
// uses adv1d_pkg for beat types, coefficients and saturation
module adv1d_flux (
    input  logic                              clk,
    input  logic                              rst_n,
    input  adv1d_pkg::rd_beat_t               rd_beat,
    input  logic signed [adv1d_pkg::Q_W-1:0]  rd_data,
    input  adv1d_pkg::coef_t                  coef,
    output adv1d_pkg::flux_beat_t             flux_beat
);
    import adv1d_pkg::*;

    logic signed [Q_W-1:0]   prev_reg, prev_next;

    stage_tag_t              a_tag_reg, a_tag_next;
    logic signed [Q_W:0]     a_d_reg, a_d_next;
    logic signed [Q_W-1:0]   a_tl_reg, a_tl_next;
    logic signed [Q_W-1:0]   a_tc_reg, a_tc_next;

    stage_tag_t              b_tag_reg, b_tag_next;
    logic signed [2*Q_W:0]   b_inv_reg, b_inv_next;
    logic signed [2*Q_W:0]   b_lw_reg, b_lw_next;
    logic signed [2*Q_W-1:0] b_c_reg, b_c_next;
    logic signed [2*Q_W-1:0] b_l_reg, b_l_next;
    logic signed [Q_W-1:0]   b_tc_reg, b_tc_next;

    stage_tag_t              c_tag_reg, c_tag_next;
    logic signed [SUM_W-1:0] c_sum_reg, c_sum_next;
    logic signed [Q_W-1:0]   c_tc_reg, c_tc_next;

    flux_beat_t              flux_reg, flux_next;
    sat_t                    q_sat;

    // left neighbor difference
    always_comb
    begin
        prev_next        = rd_beat.valid ? rd_data : prev_reg;
        a_tag_next.valid = rd_beat.valid && !rd_beat.skip;
        a_tag_next.first = rd_beat.first;
        a_tag_next.last  = rd_beat.last;
        a_d_next         = (Q_W+1)'(prev_reg) - (Q_W+1)'(rd_data);
        a_tl_next        = prev_reg;
        a_tc_next        = rd_data;
    end

    // products
    always_comb
    begin
        b_tag_next = a_tag_reg;
        b_inv_next = a_d_reg * coef.inv_delta;
        b_lw_next  = a_d_reg * coef.lw_coef;
        b_c_next   = a_tc_reg * coef.half_velocity;
        b_l_next   = a_tl_reg * coef.half_velocity;
        b_tc_next  = a_tc_reg;
    end

    // floored terms summed
    always_comb
    begin
        c_tag_next = b_tag_reg;
        c_sum_next = SUM_W'(b_inv_reg >>> 16) + SUM_W'(b_lw_reg >>> 16)
                   - SUM_W'(b_c_reg >>> 16) - SUM_W'(b_l_reg >>> 16);
        c_tc_next  = b_tc_reg;
    end

    always_comb
    begin
        q_sat           = sat32(c_sum_reg);
        flux_next.valid = c_tag_reg.valid;
        flux_next.first = c_tag_reg.first;
        flux_next.last  = c_tag_reg.last;
        flux_next.ovf   = q_sat.ovf;
        flux_next.q     = q_sat.val;
        flux_next.tc    = c_tc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_tag_reg <= '0;
            b_tag_reg <= '0;
            c_tag_reg <= '0;
            flux_reg  <= '0;
        end
        else
        begin
            a_tag_reg <= a_tag_next;
            b_tag_reg <= b_tag_next;
            c_tag_reg <= c_tag_next;
            flux_reg  <= flux_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg  <= prev_next;
        a_d_reg   <= a_d_next;
        a_tl_reg  <= a_tl_next;
        a_tc_reg  <= a_tc_next;
        b_inv_reg <= b_inv_next;
        b_lw_reg  <= b_lw_next;
        b_c_reg   <= b_c_next;
        b_l_reg   <= b_l_next;
        b_tc_reg  <= b_tc_next;
        c_sum_reg <= c_sum_next;
        c_tc_reg  <= c_tc_next;
    end

    assign flux_beat = flux_reg;

endmodule

// ===== src/adv1d_update.sv =====
// cell update pipeline: pairs neighboring fluxes, scales, saturates and
// writes the new cell values back in ascending order; uses adv1d_pkg
module adv1d_update #(
    parameter int GRID_CELLS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  adv1d_pkg::flux_beat_t             flux_beat,
    input  adv1d_pkg::coef_t                  coef,
    output logic                              wr_valid,
    output logic [$clog2(GRID_CELLS)-1:0]     wr_addr,
    output logic signed [adv1d_pkg::Q_W-1:0]  wr_data,
    output adv1d_pkg::upd_status_t            status
);
    import adv1d_pkg::*;

    localparam int AW = $clog2(GRID_CELLS);

    logic signed [Q_W-1:0]   q0_reg, q0_next;
    logic signed [Q_W-1:0]   prev_q_reg, prev_q_next;
    logic signed [Q_W-1:0]   prev_tc_reg, prev_tc_next;
    logic                    tail_reg, tail_next;

    upd_tag_t                u1_tag_reg, u1_tag_next;
    logic signed [Q_W:0]     u1_dq_reg, u1_dq_next;
    logic signed [Q_W-1:0]   u1_told_reg, u1_told_next;

    upd_tag_t                u2_tag_reg, u2_tag_next;
    logic signed [2*Q_W:0]   u2_prod_reg, u2_prod_next;
    logic signed [Q_W-1:0]   u2_told_reg, u2_told_next;

    upd_tag_t                u3_tag_reg, u3_tag_next;
    logic signed [SUM_W-2:0] u3_nv_reg, u3_nv_next;

    logic [AW-1:0]           wcnt_reg, wcnt_next;
    logic                    ovf_reg, ovf_next;
    sat_t                    cell_sat;

    // hold the first flux for the wrap face, the previous for each pair
    always_comb
    begin
        q0_next      = (flux_beat.valid && flux_beat.first) ? flux_beat.q : q0_reg;
        prev_q_next  = flux_beat.valid ? flux_beat.q : prev_q_reg;
        prev_tc_next = flux_beat.valid ? flux_beat.tc : prev_tc_reg;
        tail_next    = flux_beat.valid && flux_beat.last;
    end

    always_comb
    begin
        u1_tag_next.valid = tail_reg || (flux_beat.valid && !flux_beat.first);
        u1_tag_next.last  = tail_reg;
        if (tail_reg)
        begin
            u1_dq_next = (Q_W+1)'(prev_q_reg) - (Q_W+1)'(q0_reg);
        end
        else
        begin
            u1_dq_next = (Q_W+1)'(prev_q_reg) - (Q_W+1)'(flux_beat.q);
        end
        u1_told_next = prev_tc_reg;
    end

    always_comb
    begin
        u2_tag_next  = u1_tag_reg;
        u2_prod_next = u1_dq_reg * coef.dt_over_delta;
        u2_told_next = u1_told_reg;
        u3_tag_next  = u2_tag_reg;
        u3_nv_next   = (SUM_W-1)'(u2_told_reg) + (SUM_W-1)'(u2_prod_reg >>> 16);
    end

    always_comb
    begin
        cell_sat = sat32(SUM_W'(u3_nv_reg));
        if (start)
        begin
            wcnt_next = '0;
            ovf_next  = 1'b0;
        end
        else
        begin
            wcnt_next = u3_tag_reg.valid ? wcnt_reg + AW'(1) : wcnt_reg;
            ovf_next  = ovf_reg || (flux_beat.valid && flux_beat.ovf)
                      || (u3_tag_reg.valid && cell_sat.ovf);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_reg   <= 1'b0;
            u1_tag_reg <= '0;
            u2_tag_reg <= '0;
            u3_tag_reg <= '0;
            wcnt_reg   <= '0;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            tail_reg   <= tail_next;
            u1_tag_reg <= u1_tag_next;
            u2_tag_reg <= u2_tag_next;
            u3_tag_reg <= u3_tag_next;
            wcnt_reg   <= wcnt_next;
            ovf_reg    <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q0_reg      <= q0_next;
        prev_q_reg  <= prev_q_next;
        prev_tc_reg <= prev_tc_next;
        u1_dq_reg   <= u1_dq_next;
        u1_told_reg <= u1_told_next;
        u2_prod_reg <= u2_prod_next;
        u2_told_reg <= u2_told_next;
        u3_nv_reg   <= u3_nv_next;
    end

    assign wr_valid    = u3_tag_reg.valid;
    assign wr_addr     = wcnt_reg;
    assign wr_data     = cell_sat.val;
    assign status.done = u3_tag_reg.valid && u3_tag_reg.last;
    assign status.ovf  = ovf_reg || (u3_tag_reg.valid && cell_sat.ovf);

endmodule

// ===== src/advection_diffusion_1d_step.sv =====
// a read or a sweeping advance holds off new requests until its result is out; other
// requests are held off only while the output stalls; an advance is bound by the single
// read port of the cell memory sweeping the ring once (n + 1 reads, n = active cells
// clamped to the grid) plus the flux and update pipelines
// reset clears control and loads the register defaults; cell contents stay undefined
// top level: request control, config registers; uses adv1d_pkg and the submodules
`include "assert_macros.svh"
module advection_diffusion_1d_step #(
    parameter int GRID_CELLS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [2:0]                        cfg_index,
    input  logic [adv1d_pkg::Q_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        req_type,
    input  logic [5:0]                        cell_index,
    input  logic signed [adv1d_pkg::Q_W-1:0]  cell_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [adv1d_pkg::Q_W-1:0]  read_value,
    output logic                              overflow_flag
);
    import adv1d_pkg::*;

    localparam int AW = $clog2(GRID_CELLS);
    localparam int NW = $clog2(GRID_CELLS + 1);

    adv1d_state_t          state_reg, state_next;
    logic [6:0]            active_cells_reg;
    coef_t                 coef_reg;

    logic [NW-1:0]         n_reg, n_next;
    logic [NW-1:0]         sweep_cnt_reg, sweep_cnt_next;
    logic [NW-1:0]         n_eff;
    logic                  rd_ok_reg, rd_ok_next;
    rd_beat_t              sweep_tag_reg, sweep_tag_next;

    logic                  out_valid_reg, out_valid_next;
    logic signed [Q_W-1:0] read_value_reg, read_value_next;
    logic                  overflow_reg, overflow_next;

    logic                  accept;
    logic                  in_range;
    logic                  upd_start;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic signed [Q_W-1:0] mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic signed [Q_W-1:0] mem_rdata;

    flux_beat_t            flux_beat;
    logic                  upd_wr_valid;
    logic [AW-1:0]         upd_wr_addr;
    logic signed [Q_W-1:0] upd_wr_data;
    upd_status_t           upd_stat;

    assign in_stall = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;
    assign in_range = (32'(cell_index) < GRID_CELLS);
    assign n_eff    = (32'(active_cells_reg) > GRID_CELLS) ? NW'(GRID_CELLS)
                                                           : NW'(active_cells_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_cells_reg       <= RST_ACTIVE_CELLS;
            coef_reg.inv_delta     <= RST_INV_DELTA;
            coef_reg.half_velocity <= RST_HALF_VELOCITY;
            coef_reg.lw_coef       <= RST_LW_COEF;
            coef_reg.dt_over_delta <= RST_DT_OVER_DELTA;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_ACTIVE_CELLS:  active_cells_reg       <= cfg_data[6:0];
                CFG_INV_DELTA:     coef_reg.inv_delta     <= cfg_data;
                CFG_HALF_VELOCITY: coef_reg.half_velocity <= cfg_data;
                CFG_LW_COEF:       coef_reg.lw_coef       <= cfg_data;
                CFG_DT_OVER_DELTA: coef_reg.dt_over_delta <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == REQ_READ)
                    begin
                        state_next = ST_READ;
                    end
                    else if ((req_type == REQ_ADVANCE) && (n_eff != '0))
                    begin
                        state_next = ST_SWEEP;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            ST_SWEEP:
            begin
                if (sweep_cnt_reg == n_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (upd_stat.done)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        n_next          = n_reg;
        sweep_cnt_next  = sweep_cnt_reg;
        rd_ok_next      = rd_ok_reg;
        sweep_tag_next  = '0;
        upd_start       = 1'b0;
        mem_re          = 1'b0;
        mem_raddr       = AW'(cell_index);
        out_valid_next  = out_valid_reg && out_stall;
        read_value_next = read_value_reg;
        overflow_next   = overflow_reg;
        mem_we          = upd_wr_valid;
        mem_waddr       = upd_wr_addr;
        mem_wdata       = upd_wr_data;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_type)
                        REQ_WRITE:
                        begin
                            mem_we          = in_range;
                            mem_waddr       = AW'(cell_index);
                            mem_wdata       = cell_value;
                            out_valid_next  = 1'b1;
                            read_value_next = '0;
                            overflow_next   = 1'b0;
                        end
                        REQ_ADVANCE:
                        begin
                            if (n_eff == '0)
                            begin
                                out_valid_next  = 1'b1;
                                read_value_next = '0;
                                overflow_next   = 1'b0;
                            end
                            else
                            begin
                                n_next         = n_eff;
                                sweep_cnt_next = '0;
                                upd_start      = 1'b1;
                            end
                        end
                        REQ_READ:
                        begin
                            mem_re     = 1'b1;
                            rd_ok_next = in_range;
                        end
                        default:
                        begin
                            out_valid_next  = 1'b1;
                            read_value_next = '0;
                            overflow_next   = 1'b0;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                out_valid_next  = 1'b1;
                read_value_next = rd_ok_reg ? mem_rdata : '0;
                overflow_next   = 1'b0;
            end
            ST_SWEEP:
            begin
                // left neighbor of cell 0 first, then cells 0 to n-1
                mem_re = 1'b1;
                if (sweep_cnt_reg == '0)
                begin
                    mem_raddr = AW'(n_reg - NW'(1));
                end
                else
                begin
                    mem_raddr = AW'(sweep_cnt_reg - NW'(1));
                end
                sweep_tag_next.valid = 1'b1;
                sweep_tag_next.skip  = (sweep_cnt_reg == '0);
                sweep_tag_next.first = (sweep_cnt_reg == NW'(1));
                sweep_tag_next.last  = (sweep_cnt_reg == n_reg);
                sweep_cnt_next       = sweep_cnt_reg + NW'(1);
            end
            ST_DRAIN:
            begin
                if (upd_stat.done)
                begin
                    out_valid_next  = 1'b1;
                    read_value_next = '0;
                    overflow_next   = upd_stat.ovf;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= '0;
            sweep_cnt_reg <= '0;
            rd_ok_reg     <= 1'b0;
            sweep_tag_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            sweep_cnt_reg <= sweep_cnt_next;
            rd_ok_reg     <= rd_ok_next;
            sweep_tag_reg <= sweep_tag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        read_value_reg <= read_value_next;
        overflow_reg   <= overflow_next;
    end

    adv1d_cell_mem #(
        .GRID_CELLS (GRID_CELLS)
    ) u_cell_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    adv1d_flux u_flux (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_beat   (sweep_tag_reg),
        .rd_data   (mem_rdata),
        .coef      (coef_reg),
        .flux_beat (flux_beat)
    );

    adv1d_update #(
        .GRID_CELLS (GRID_CELLS)
    ) u_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (upd_start),
        .flux_beat (flux_beat),
        .coef      (coef_reg),
        .wr_valid  (upd_wr_valid),
        .wr_addr   (upd_wr_addr),
        .wr_data   (upd_wr_data),
        .status    (upd_stat)
    );

    assign out_valid     = out_valid_reg;
    assign read_value    = read_value_reg;
    assign overflow_flag = overflow_reg;

    // write-back always trails the sweep reads, never the same cell at once
    `ADV_NEVER(a_rw_same_cell, mem_we && mem_re && (mem_waddr == mem_raddr))
    `ADV_ASSERT(a_done_in_drain, upd_stat.done |-> (state_reg == ST_DRAIN))
    `ADV_ASSERT(a_out_empty_busy, (state_reg != ST_IDLE) |-> !out_valid_reg)
    `ADV_ASSERT(a_sweep_bound, (state_reg == ST_SWEEP) |-> (sweep_cnt_reg <= n_reg))

endmodule
